>>> hw/rtl/great_circle_initial_bearing_defines.svh
// Assertion macros shared by the RTL
`ifndef GREAT_CIRCLE_INITIAL_BEARING_DEFINES_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_DEFINES_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define GCIB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCIB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gcib_pkg.sv
`timescale 1ns / 1ps
package gcib_pkg;

    localparam int CW        = 36;
    localparam int TABLE_LEN = 40;

    typedef logic signed [CW-1:0] t_cw;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [34:0] DEG_TURN   = 35'sd3019898880;
    localparam logic [32:0] RECIP_45          = 33'd6108397933;  // ceil(2^38/45)
    localparam logic [31:0] COURSE_MAX        = 32'd3019898879;

    // arctangent of 2^-i in binary-angle units
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        unique case (idx)
            0: v = 32'd536870912;   1: v = 32'd316933406;
            2: v = 32'd167458907;   3: v = 32'd85004756;
            4: v = 32'd42667331;    5: v = 32'd21354465;
            6: v = 32'd10679838;    7: v = 32'd5340245;
            8: v = 32'd2670163;     9: v = 32'd1335087;
            10: v = 32'd667544;     11: v = 32'd333772;
            12: v = 32'd166886;     13: v = 32'd83443;
            14: v = 32'd41722;      15: v = 32'd20861;
            16: v = 32'd10430;      17: v = 32'd5215;
            18: v = 32'd2608;       19: v = 32'd1304;
            20: v = 32'd652;        21: v = 32'd326;
            22: v = 32'd163;        23: v = 32'd81;
            24: v = 32'd41;         25: v = 32'd20;
            26: v = 32'd10;         27: v = 32'd5;
            28: v = 32'd3;          29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/gcib_deg2bam.sv
`timescale 1ns / 1ps
// degrees*2^23 -> 32-bit binary angle, round(d*64/45) after mod 360; registered in r_r1, r_k, r_bam
module gcib_deg2bam
    import gcib_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_deg,
    output logic        [31:0] o_bam
);

    logic signed [34:0] w_d;
    logic        [31:0] n_r;
    logic        [31:0] r_r1;
    logic        [31:0] r_r2;
    logic        [26:0] r_k;
    logic        [64:0] w_prod;
    logic        [31:0] w_rem_full;
    logic        [5:0]  w_rem;
    logic        [31:0] w_lo_prod;
    logic        [32:0] w_bam;
    logic        [31:0] r_bam;

    // input lies within two turns either way
    always_comb begin
        w_d = 35'(i_deg);
        if (w_d <= -DEG_TURN) begin
            n_r = 32'(w_d + (DEG_TURN <<< 1));
        end else if (w_d < 0) begin
            n_r = 32'(w_d + DEG_TURN);
        end else if (w_d >= DEG_TURN) begin
            n_r = 32'(w_d - DEG_TURN);
        end else begin
            n_r = 32'(w_d);
        end
    end

    assign w_prod = 65'(r_r1) * 65'(RECIP_45);

    // r = 45k + m, so r*64+22 over 45 is 64k + (64m+22)/45
    assign w_rem_full = r_r2 - 32'(32'(r_k) * 32'd45);
    assign w_rem      = w_rem_full[5:0];
    assign w_lo_prod  = (32'({w_rem, 6'b0}) + 32'd22) * 32'd23302;
    assign w_bam      = {r_k, 6'b0} + 33'(w_lo_prod[25:20]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1  <= n_r;
            r_r2  <= r_r1;
            r_k   <= w_prod[64:38];
            r_bam <= w_bam[31:0];
        end
    end

    assign o_bam = r_bam;

endmodule

>>> hw/rtl/gcib_cell.sv
`timescale 1ns / 1ps
// one CORDIC micro-rotation, registered
module gcib_cell
    import gcib_pkg::*;
#(
    parameter int IDX       = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_cw  i_x,
    input  t_cw  i_y,
    input  t_cw  i_z,
    input  logic i_tag,
    output t_cw  o_x,
    output t_cw  o_y,
    output t_cw  o_z,
    output logic o_tag
);

    t_cw  w_dx;
    t_cw  w_dy;
    t_cw  w_at;
    logic w_pos;
    logic w_cw;
    t_cw  n_x;
    t_cw  n_y;
    t_cw  n_z;
    t_cw  r_x;
    t_cw  r_y;
    t_cw  r_z;
    logic r_tag;

    always_comb begin
        w_dx  = i_y >>> IDX;
        w_dy  = i_x >>> IDX;
        w_at  = CW'(atan_entry(IDX));
        w_pos = VECTORING ? !i_y[CW-1] : !i_z[CW-1];
        w_cw  = VECTORING ? !w_pos : w_pos;
        if (w_cw) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_at;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;

endmodule

>>> hw/rtl/gcib_chain.sv
`timescale 1ns / 1ps
// row of CORDIC cells, each stage registered
module gcib_chain
    import gcib_pkg::*;
#(
    parameter int STAGES    = 28,
    parameter bit VECTORING = 1'b0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_cw  i_x,
    input  t_cw  i_y,
    input  t_cw  i_z,
    input  logic i_tag,
    output t_cw  o_x,
    output t_cw  o_y,
    output t_cw  o_z,
    output logic o_tag
);

    t_cw  w_x   [0:STAGES];
    t_cw  w_y   [0:STAGES];
    t_cw  w_z   [0:STAGES];
    logic w_tag [0:STAGES];

    assign w_x[0]   = i_x;
    assign w_y[0]   = i_y;
    assign w_z[0]   = i_z;
    assign w_tag[0] = i_tag;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        gcib_cell #(
            .IDX       (g),
            .VECTORING (VECTORING)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_x[g]),
            .i_y   (w_y[g]),
            .i_z   (w_z[g]),
            .i_tag (w_tag[g]),
            .o_x   (w_x[g+1]),
            .o_y   (w_y[g+1]),
            .o_z   (w_z[g+1]),
            .o_tag (w_tag[g+1])
        );
    end

    assign o_x   = w_x[STAGES];
    assign o_y   = w_y[STAGES];
    assign o_z   = w_z[STAGES];
    assign o_tag = w_tag[STAGES];

endmodule

>>> hw/rtl/great_circle_initial_bearing.sv
`timescale 1ns / 1ps
// Channel  | Dir | Fields
// s_axis   | in  | tdata: origin_lat[30:0] origin_lon[62:31] dest_lat[93:63] dest_lon[125:94]
// m_axis   | out | tdata: course[31:0]
//
// One transaction per cycle sustained while the output is not stalled; N = min(CORDIC_STAGES, 40)
// is the cell count of each of the two cell rows (sine/cosine rotation and atan2 vectoring).
// Reset (synchronous, active low) clears only the valid pipeline and output flag.
// A stalled output holds the pipe only while its last slot is full; else it advances and takes input.
module great_circle_initial_bearing
    import gcib_pkg::*;
#(
    parameter int CORDIC_STAGES = 28
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // origin_lat, origin_lon, dest_lat, dest_lon, pad
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata    // course
);

    `include "great_circle_initial_bearing_defines.svh"

    localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int LAT = 6 + 2 * NST;

    logic             w_out_load;
    logic             w_en;
    logic             w_acc;
    logic [LAT-1:0]   r_v;
    logic             r_out_valid;
    logic [31:0]      r_course;

    logic signed [32:0] w_deg [0:2];
    logic        [31:0] w_bam [0:2];
    t_cw                w_rx  [0:2];
    t_cw                w_ry  [0:2];
    t_cw                w_rz  [0:2];
    logic               w_rneg[0:2];
    t_cw                w_ox  [0:2];
    t_cw                w_oy  [0:2];
    t_cw                w_oz  [0:2];
    logic               w_oneg[0:2];

    logic signed [31:0] w_s1, w_c1, w_s2, w_c2, w_sd, w_cd;
    logic signed [63:0] w_p_num, w_p_t1, w_p_p, w_p_t;
    logic signed [31:0] r_num1, r_t1, r_p1, r_cd1;
    logic signed [31:0] r_num2, r_p2, r_t2;
    logic signed [32:0] w_den;
    t_cw                r_vx, r_vy, r_vz;
    logic               r_vzero;
    t_cw                w_vx_o, w_vy_o, w_vz_o;
    logic               w_vzero_o;
    logic        [37:0] w_cprod;
    logic        [31:0] n_course;

    assign w_out_load      = i_m_axis_tready || !r_out_valid;
    assign w_en            = w_out_load || !r_v[LAT-1];
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;

    assign w_deg[0] = 33'(signed'(i_s_axis_tdata[30:0]));
    assign w_deg[1] = 33'(signed'(i_s_axis_tdata[93:63]));
    assign w_deg[2] = 33'(signed'(i_s_axis_tdata[125:94])) - 33'(signed'(i_s_axis_tdata[62:31]));

    // lanes: latitude 1, latitude 2, longitude difference
    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [31:0] w_sum;
        logic [31:0] w_a;

        gcib_deg2bam u_d2b (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_deg (w_deg[l]),
            .o_bam (w_bam[l])
        );

        // second and third quadrants turned by half a turn, result negated later
        assign w_sum     = w_bam[l] + QUARTER_TURN;
        assign w_rneg[l] = w_sum[31];
        assign w_a       = w_sum[31] ? (w_bam[l] - HALF_TURN) : w_bam[l];
        assign w_rx[l]   = GAIN_Q30;
        assign w_ry[l]   = '0;
        assign w_rz[l]   = CW'(signed'(w_a));

        gcib_chain #(
            .STAGES    (NST),
            .VECTORING (1'b0)
        ) u_rot (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_rx[l]),
            .i_y   (w_ry[l]),
            .i_z   (w_rz[l]),
            .i_tag (w_rneg[l]),
            .o_x   (w_ox[l]),
            .o_y   (w_oy[l]),
            .o_z   (w_oz[l]),
            .o_tag (w_oneg[l])
        );
    end

    assign w_c1 = 32'(w_oneg[0] ? -w_ox[0] : w_ox[0]);
    assign w_s1 = 32'(w_oneg[0] ? -w_oy[0] : w_oy[0]);
    assign w_c2 = 32'(w_oneg[1] ? -w_ox[1] : w_ox[1]);
    assign w_s2 = 32'(w_oneg[1] ? -w_oy[1] : w_oy[1]);
    assign w_cd = 32'(w_oneg[2] ? -w_ox[2] : w_ox[2]);
    assign w_sd = 32'(w_oneg[2] ? -w_oy[2] : w_oy[2]);

    assign w_p_num = 64'(w_sd) * 64'(w_c2);
    assign w_p_t1  = 64'(w_s1) * 64'(w_c2);
    assign w_p_p   = 64'(w_c1) * 64'(w_s2);
    assign w_p_t   = 64'(r_t1) * 64'(r_cd1);
    assign w_den   = 33'(r_p2) - 33'(r_t2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num1 <= 32'(w_p_num >>> 30);
            r_t1   <= 32'(w_p_t1 >>> 30);
            r_p1   <= 32'(w_p_p >>> 30);
            r_cd1  <= w_cd;
            r_num2 <= r_num1;
            r_p2   <= r_p1;
            r_t2   <= 32'(w_p_t >>> 30);
            r_vzero <= (r_num2 == 32'sd0) && (w_den == 33'sd0);
            // negative x: turn the vector by half a turn first
            if (w_den < 0) begin
                r_vx <= -CW'(w_den);
                r_vy <= -CW'(r_num2);
                r_vz <= CW'(HALF_TURN);
            end else begin
                r_vx <= CW'(w_den);
                r_vy <= CW'(r_num2);
                r_vz <= '0;
            end
        end
    end

    gcib_chain #(
        .STAGES    (NST),
        .VECTORING (1'b1)
    ) u_vec (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_vx),
        .i_y   (r_vy),
        .i_z   (r_vz),
        .i_tag (r_vzero),
        .o_x   (w_vx_o),
        .o_y   (w_vy_o),
        .o_z   (w_vz_o),
        .o_tag (w_vzero_o)
    );

    // binary angle -> degrees*2^23, floor((a*45 + 32) / 64)
    assign w_cprod  = 38'(w_vz_o[31:0]) * 38'd45 + 38'd32;
    assign n_course = w_vzero_o ? 32'd0 : w_cprod[37:6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[LAT-2:0], w_acc};
            end
            if (w_out_load) begin
                r_out_valid <= r_v[LAT-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_course <= n_course;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_course;

    `GCIB_ASSERT_IMP(a_course_range, r_out_valid, r_course <= COURSE_MAX,
        "course out of range")
    `GCIB_ASSERT_IMP(a_no_overrun, r_out_valid && !i_m_axis_tready && r_v[LAT-1], !w_en,
        "pipeline advanced into a held result")
    `GCIB_ASSERT_NXT(a_accept_enters, w_acc, r_v[0],
        "accepted transaction missing from pipeline")

endmodule
